// ===== rtl/mcpl_pkg.sv =====
// Shared types and constants for the minimum-cost priority list.
package mcpl_pkg;

    localparam int ID_W   = 16;
    localparam int COST_W = 31;
    localparam int OCC_W  = 7;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    // Width of the groups that the query flags are OR-ed over per cycle.
    localparam int FOLD_GROUP = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_POP      = 2'd1,
        FUNC_CONTAINS = 2'd2,
        FUNC_CLEAR    = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [COST_W-1:0] cost;
    } entry_t;

    typedef struct packed {
        logic add;
        logic pop;
        logic clear;
        logic query;
        logic fold;
    } chain_cmd_t;

endpackage

// ===== rtl/min_cost_priority_list_top.sv =====
// Top level of the minimum-cost priority list: control, entry count and result register.
//
//  Channel   Direction  Carries
//  s_axis    in         tuser: func[1:0]; tdata: entry_id[15:0], entry_cost[46:16]
//  m_axis    out        tdata: out_id[15:0], out_cost[46:16], found[47],
//                              status[49:48], occupancy[56:50]
//
// For add, pop and clear the cells act on the edge that takes the transaction;
// the output register then loads from the result state. A contains query first
// runs one OR fold over the cell flags per fold-state step (two folds at 64 entries).
// Reset empties every cell at once; no clearing pass is needed.
// A stalled output holds the block in its result state until the slot frees.
module min_cost_priority_list_top
    import mcpl_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // entry_id, entry_cost
    input  logic [FUNC_W-1:0]     s_axis_tuser,  // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // out_id, out_cost, found, status, occupancy
);

    // Number of OR folds that reduce one flag per cell down to a single flag.
    function automatic int fold_count(int n);
        int folds;
        int span;
        folds = 1;
        span  = FOLD_GROUP;
        while (span < n)
        begin
            span  = span * FOLD_GROUP;
            folds = folds + 1;
        end
        return folds;
    endfunction

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int FOLDS  = fold_count(CAPACITY);
    localparam int FCNT_W = (FOLDS > 1) ? $clog2(FOLDS) : 1;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [FCNT_W-1:0] fcnt_reg;
    logic [FCNT_W-1:0] fcnt_next;

    logic [ID_W-1:0]   res_id_reg;
    logic [COST_W-1:0] res_cost_reg;
    status_t           res_status_reg;
    logic              res_query_reg;
    logic [ID_W-1:0]   res_id_next;
    logic [COST_W-1:0] res_cost_next;
    status_t           res_status_next;
    logic              res_query_next;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    func_t      in_func;
    entry_t     in_entry;
    logic       accept;
    logic       full;
    logic       empty;
    logic       out_free;
    logic       out_load;
    chain_cmd_t cmd;
    entry_t     head_entry;
    logic       found;

    assign in_func       = func_t'(s_axis_tuser);
    assign in_entry.id   = s_axis_tdata[ID_W-1:0];
    assign in_entry.cost = s_axis_tdata[ID_W +: COST_W];
    assign full          = (count_reg == CNT_W'(CAPACITY));
    assign empty         = (count_reg == '0);
    assign out_free      = !out_valid_reg || m_axis_tready;

    mcpl_chain #(
        .CAPACITY(CAPACITY)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .new_entry (in_entry),
        .head_entry(head_entry),
        .found     (found)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = (in_func == FUNC_CONTAINS) ? ST_FOLD : ST_RESULT;
                end
            end
            ST_FOLD:
            begin
                if (fcnt_reg == '0)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        s_axis_tready = 1'b0;
        accept        = 1'b0;
        out_load      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                accept        = s_axis_tvalid;
                cmd.add       = accept && (in_func == FUNC_ADD) && !full;
                cmd.pop       = accept && (in_func == FUNC_POP) && !empty;
                cmd.clear     = accept && (in_func == FUNC_CLEAR);
                cmd.query     = accept && (in_func == FUNC_CONTAINS);
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            ST_RESULT:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Entry count, fold counter and pending result.
    always_comb
    begin
        count_next      = count_reg;
        fcnt_next       = fcnt_reg;
        res_id_next     = res_id_reg;
        res_cost_next   = res_cost_reg;
        res_status_next = res_status_reg;
        res_query_next  = res_query_reg;

        if (accept)
        begin
            res_id_next     = '0;
            res_cost_next   = '0;
            res_status_next = STAT_OK;
            res_query_next  = (in_func == FUNC_CONTAINS);
            fcnt_next       = FCNT_W'(FOLDS - 1);
            case (in_func)
                FUNC_ADD:
                begin
                    if (full)
                    begin
                        res_status_next = STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_POP:
                begin
                    if (empty)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        res_id_next   = head_entry.id;
                        res_cost_next = head_entry.cost;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        else if (cmd.fold && (fcnt_reg != '0))
        begin
            fcnt_next = fcnt_reg - FCNT_W'(1);
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[ID_W-1:0]                        = res_id_reg;
        out_data_next[ID_W +: COST_W]                  = res_cost_reg;
        out_data_next[ID_W + COST_W]                   = res_query_reg && found;
        out_data_next[ID_W + COST_W + 1 +: STAT_W]     = res_status_reg;
        out_data_next[ID_W + COST_W + 1 + STAT_W +: OCC_W] = OCC_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fcnt_reg       <= fcnt_next;
        res_id_reg     <= res_id_next;
        res_cost_reg   <= res_cost_next;
        res_status_reg <= res_status_next;
        res_query_reg  <= res_query_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/mcpl_cell.sv =====
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
module mcpl_cell
    import mcpl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_cmd_t cmd,
    input  entry_t     new_entry,
    input  logic       left_valid,
    input  entry_t     left_entry,
    input  logic       left_keep,
    input  logic       right_valid,
    input  entry_t     right_entry,
    output logic       valid,
    output entry_t     entry,
    output logic       keep,
    output logic       match
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;

    // A held entry stays in place on an add when its cost does not exceed the new
    // cost, so equal costs keep their arrival order.
    assign keep  = valid_reg && (entry_reg.cost <= new_entry.cost);
    assign match = valid_reg && (entry_reg.id == new_entry.id);
    assign valid = valid_reg;
    assign entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.add && !keep)
        begin
            if (left_keep)
            begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
            else
            begin
                valid_next = left_valid;
                entry_next = left_entry;
            end
        end
        else if (cmd.pop)
        begin
            valid_next = right_valid;
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/mcpl_chain.sv =====
// Row of sorted cells with the folding OR register that answers membership queries.
module mcpl_chain
    import mcpl_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_cmd_t cmd,
    input  entry_t     new_entry,
    output entry_t     head_entry,
    output logic       found
);

    logic                valid_w [CAPACITY];
    entry_t              entry_w [CAPACITY];
    logic [CAPACITY-1:0] keep_w;
    logic [CAPACITY-1:0] match_w;

    logic [CAPACITY-1:0] fold_reg;
    logic [CAPACITY-1:0] fold_next;
    logic [CAPACITY-1:0] fold_step;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic   lv;
            entry_t le;
            logic   lk;
            logic   rv;
            entry_t re;

            if (k == 0)
            begin : g_first
                // The head sees a phantom neighbor that always keeps its place.
                assign lv = 1'b0;
                assign le = new_entry;
                assign lk = 1'b1;
            end
            else
            begin : g_mid
                assign lv = valid_w[k-1];
                assign le = entry_w[k-1];
                assign lk = keep_w[k-1];
            end

            if (k == CAPACITY - 1)
            begin : g_last
                assign rv = 1'b0;
                assign re = '0;
            end
            else
            begin : g_inner
                assign rv = valid_w[k+1];
                assign re = entry_w[k+1];
            end

            mcpl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .new_entry  (new_entry),
                .left_valid (lv),
                .left_entry (le),
                .left_keep  (lk),
                .right_valid(rv),
                .right_entry(re),
                .valid      (valid_w[k]),
                .entry      (entry_w[k]),
                .keep       (keep_w[k]),
                .match      (match_w[k])
            );
        end
    endgenerate

    assign head_entry = entry_w[0];

    // Each fold step ORs groups of eight flags into one, packing the results low.
    always_comb
    begin
        logic acc;
        fold_step = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            acc = 1'b0;
            for (int b = 0; b < FOLD_GROUP; b++)
            begin
                if (j * FOLD_GROUP + b < CAPACITY)
                begin
                    acc = acc | fold_reg[j * FOLD_GROUP + b];
                end
            end
            fold_step[j] = acc;
        end
    end

    always_comb
    begin
        fold_next = fold_reg;
        if (cmd.query)
        begin
            fold_next = match_w;
        end
        else if (cmd.fold)
        begin
            fold_next = fold_step;
        end
    end

    always_ff @(posedge clk)
    begin
        fold_reg <= fold_next;
    end

    assign found = fold_reg[0];

endmodule
